@@ design/beq_pkg.sv @@
`default_nettype none

package beq_pkg;

    // Width of the millisecond time base; all stamps and differences wrap at this width.
    localparam int TIME_WIDTH = 32;

    localparam int CFG_INDEX_WIDTH = 3;
    localparam int CFG_DATA_WIDTH  = 16;
    localparam int VALUE_WIDTH     = 8;

    typedef logic [TIME_WIDTH-1:0] stamp_t;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_DEBOUNCE_MS     = 3'd0,
        REG_DOUBLE_CLICK_MS = 3'd1,
        REG_LONG_PRESS_MS   = 3'd2,
        REG_DOUBLE_MODE     = 3'd3,
        REG_LONG_MODE       = 3'd4,
        REG_SWITCH_KIND     = 3'd5,
        REG_OPTION_FLAGS    = 3'd6,
        REG_DIMMER_LEVEL    = 3'd7
    } reg_index_t;

    typedef enum logic [1:0] {
        MODE_OFF  = 2'd0,
        MODE_LOW  = 2'd1,
        MODE_HIGH = 2'd2,
        MODE_BOTH = 2'd3
    } level_mode_t;

    typedef enum logic [1:0] {
        KIND_NORMAL    = 2'd0,
        KIND_PUSH_LOW  = 2'd1,
        KIND_PUSH_HIGH = 2'd2,
        KIND_DIMMER    = 2'd3
    } switch_kind_t;

    // option_flags bit positions
    localparam int OPT_SAFE    = 0;
    localparam int OPT_INVERT  = 1;
    localparam int OPT_MONITOR = 2;

    localparam logic [VALUE_WIDTH-1:0] VAL_DOUBLE     = 8'd3;
    localparam logic [VALUE_WIDTH-1:0] VAL_SAFE_FALSE = 8'd4;
    localparam logic [VALUE_WIDTH-1:0] VAL_LONG_LOW   = 8'd10;
    localparam logic [VALUE_WIDTH-1:0] VAL_LONG_HIGH  = 8'd11;

    localparam logic [1:0] CLICKS_DOUBLE = 2'd3;

    typedef struct packed {
        logic [15:0]      debounce_ms;
        logic [15:0]      double_click_ms;
        logic [15:0]      long_press_ms;
        level_mode_t      double_mode;
        level_mode_t      long_mode;
        switch_kind_t     kind;
        logic [2:0]       options;
        logic [7:0]       dimmer_level;
    } cfg_t;

    typedef struct packed {
        logic   last_level;
        logic   out_state;
        logic   shown_value;
        logic   safe_pending;
        logic [1:0] click_count;
        logic   long_fired;
        stamp_t debounce_stamp;
        stamp_t click_stamp;
        stamp_t press_stamp;
    } btn_state_t;

    typedef struct packed {
        logic                   task_event;
        logic                   monitor_event;
        logic [VALUE_WIDTH-1:0] event_value;
        logic                   display_value;
        logic                   output_state;
    } result_t;

    function automatic logic mode_matches(level_mode_t mode, logic level);
        return (mode == MODE_BOTH) || (mode == MODE_LOW && !level) ||
               (mode == MODE_HIGH && level);
    endfunction

endpackage

`default_nettype wire

@@ design/button_event_qualifier.sv @@
// Push button / switch event qualifier.
// Input channel (in_valid/in_stall): one polled sample per transfer: pin_valid,
// pin_level, a wrapping millisecond stamp now_ms and force_event. A transfer
// happens on a rising edge with in_valid high and in_stall low.
// Output channel (out_valid/out_stall): exactly one result per sample, in
// order: task_event, monitor_event, event_value, display_value, output_state.
// Config channel (cfg_valid/cfg_ready): cfg_index picks the register, cfg_data
// carries the value (low bits used); cfg_ready is always high. Write only idle.
// Path: an input transfer fills the sample register; when the result register is
// free or draining, the sample moves on into it and out_valid rises.
// Throughput: one sample per cycle while out_stall is low; the combinational decide
// logic between the two registers is the only work per sample.
// Stall: while out_stall holds a full result register, the sample register
// waits and in_stall rises once it is occupied; nothing is dropped.
// Reset: channels empty, button state zero, registers at defaults
// (debounce 50, double click 1000, long press 1000, others 0).
`default_nettype none

module button_event_qualifier
    import beq_pkg::*;
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    // sample channel
    input  wire logic                       in_valid,
    output logic                            in_stall,
    input  wire logic                       pin_valid,
    input  wire logic                       pin_level,
    input  wire logic [TIME_WIDTH-1:0]      now_ms,
    input  wire logic                       force_event,
    // result channel
    output logic                            out_valid,
    input  wire logic                       out_stall,
    output logic                            task_event,
    output logic                            monitor_event,
    output logic [VALUE_WIDTH-1:0]          event_value,
    output logic                            display_value,
    output logic                            output_state,
    // configuration write channel
    input  wire logic                       cfg_valid,
    output logic                            cfg_ready,
    input  wire logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  wire logic [CFG_DATA_WIDTH-1:0]  cfg_data
);

    cfg_t       cfg_reg;
    btn_state_t state_reg;
    btn_state_t state_next;
    result_t    res_next;
    result_t    res_reg;

    // sample register
    logic       s1_valid_reg;
    logic       s1_pin_valid_reg;
    logic       s1_level_reg;
    stamp_t     s1_now_reg;
    logic       s1_force_reg;

    logic       out_valid_reg;
    logic       advance;
    logic       in_take;

    // sample moves into the result register when that one is free or draining
    assign advance   = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = s1_valid_reg && !advance;
    assign in_take   = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_ms     <= 16'd50;
            cfg_reg.double_click_ms <= 16'd1000;
            cfg_reg.long_press_ms   <= 16'd1000;
            cfg_reg.double_mode     <= MODE_OFF;
            cfg_reg.long_mode       <= MODE_OFF;
            cfg_reg.kind            <= KIND_NORMAL;
            cfg_reg.options         <= '0;
            cfg_reg.dimmer_level    <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (reg_index_t'(cfg_index))
                REG_DEBOUNCE_MS:     cfg_reg.debounce_ms     <= cfg_data;
                REG_DOUBLE_CLICK_MS: cfg_reg.double_click_ms <= cfg_data;
                REG_LONG_PRESS_MS:   cfg_reg.long_press_ms   <= cfg_data;
                REG_DOUBLE_MODE:     cfg_reg.double_mode     <= level_mode_t'(cfg_data[1:0]);
                REG_LONG_MODE:       cfg_reg.long_mode       <= level_mode_t'(cfg_data[1:0]);
                REG_SWITCH_KIND:     cfg_reg.kind            <= switch_kind_t'(cfg_data[1:0]);
                REG_OPTION_FLAGS:    cfg_reg.options         <= cfg_data[2:0];
                REG_DIMMER_LEVEL:    cfg_reg.dimmer_level    <= cfg_data[7:0];
                default:             ;
            endcase
        end
    end

    beq_decide u_decide (
        .cfg         (cfg_reg),
        .cur         (state_reg),
        .pin_valid   (s1_pin_valid_reg),
        .pin_level   (s1_level_reg),
        .now_ms      (s1_now_reg),
        .force_event (s1_force_reg),
        .nxt         (state_next),
        .res         (res_next)
    );

    // control: valid flags and button state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            if (in_take)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_pin_valid_reg <= pin_valid;
            s1_level_reg     <= pin_level;
            s1_now_reg       <= now_ms;
            s1_force_reg     <= force_event;
        end
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign task_event    = res_reg.task_event;
    assign monitor_event = res_reg.monitor_event;
    assign event_value   = res_reg.event_value;
    assign display_value = res_reg.display_value;
    assign output_state  = res_reg.output_state;

endmodule

`default_nettype wire

@@ design/beq_decide.sv @@
`default_nettype none

// One sample's decision: next state and result from current state and config.
module beq_decide
    import beq_pkg::*;
(
    input  wire cfg_t       cfg,
    input  wire btn_state_t cur,
    input  wire logic       pin_valid,
    input  wire logic       pin_level,
    input  wire stamp_t     now_ms,
    input  wire logic       force_event,
    output btn_state_t      nxt,
    output result_t         res
);

    stamp_t     since_debounce;
    stamp_t     since_click;
    stamp_t     since_press;
    logic       changed;
    logic       inv;
    logic       mon_on;
    logic       debounce_ok;
    logic       click_expired;
    logic       long_due;
    logic       long_needed;
    logic       new_out;
    logic       send;
    logic [1:0] clicks;

    assign since_debounce = now_ms - cur.debounce_stamp;
    assign since_click    = now_ms - cur.click_stamp;
    assign since_press    = now_ms - cur.press_stamp;

    assign changed       = pin_level != cur.last_level;
    assign inv           = cfg.options[OPT_INVERT];
    assign mon_on        = cfg.options[OPT_MONITOR];
    assign debounce_ok   = since_debounce >= stamp_t'(cfg.debounce_ms);
    assign click_expired = since_click >= stamp_t'(cfg.double_click_ms);
    assign long_due      = since_press >= stamp_t'(cfg.long_press_ms);

    always_comb
    begin
        nxt  = cur;
        res  = '0;
        send = 1'b0;

        clicks = (click_expired || cur.click_count == CLICKS_DOUBLE) ? 2'd0 : cur.click_count;
        if (clicks != 2'd0 || mode_matches(cfg.double_mode, pin_level))
        begin
            clicks = clicks + 2'd1;
        end

        case (cfg.kind)
            KIND_NORMAL:    new_out = pin_level;
            KIND_PUSH_LOW:  new_out = pin_level ? cur.out_state : !cur.out_state;
            KIND_PUSH_HIGH: new_out = pin_level ? !cur.out_state : cur.out_state;
            default:        new_out = cur.out_state;
        endcase

        long_needed = (cfg.kind == KIND_NORMAL) ||
                      (cfg.kind == KIND_PUSH_LOW && !pin_level) ||
                      (cfg.kind == KIND_PUSH_HIGH && pin_level);

        if (!pin_valid)
        begin
            // sample ignored
        end
        else if (cfg.options[OPT_SAFE] && changed && !cur.safe_pending)
        begin
            nxt.safe_pending = 1'b1;
        end
        else if (changed || force_event)
        begin
            nxt.safe_pending = 1'b0;
            nxt.press_stamp  = now_ms;
            nxt.long_fired   = 1'b0;
            if (debounce_ok)
            begin
                if (click_expired || cur.click_count == CLICKS_DOUBLE)
                begin
                    nxt.click_stamp = now_ms;
                end
                nxt.click_count    = clicks;
                nxt.last_level     = pin_level;
                nxt.debounce_stamp = now_ms;
                if (new_out != cur.out_state || force_event)
                begin
                    send = new_out ^ inv;
                    nxt.out_state   = new_out;
                    nxt.shown_value = send;
                    res.task_event    = 1'b1;
                    res.monitor_event = mon_on;
                    if (cfg.kind == KIND_DIMMER && send)
                    begin
                        res.event_value = cfg.dimmer_level;
                    end
                    else if (clicks == CLICKS_DOUBLE && cfg.double_mode != MODE_OFF)
                    begin
                        res.event_value = VAL_DOUBLE;
                    end
                    else
                    begin
                        res.event_value = {{(VALUE_WIDTH-1){1'b0}}, send};
                    end
                end
            end
        end
        else if (!cur.long_fired && mode_matches(cfg.long_mode, pin_level))
        begin
            nxt.safe_pending = 1'b0;
            if (long_due)
            begin
                nxt.long_fired = 1'b1;
                if (long_needed)
                begin
                    send = pin_level ^ inv;
                    nxt.shown_value   = send;
                    res.task_event    = 1'b1;
                    res.monitor_event = mon_on;
                    res.event_value   = send ? VAL_LONG_HIGH : VAL_LONG_LOW;
                end
            end
        end
        else if (cur.safe_pending)
        begin
            // change did not persist: false positive
            nxt.safe_pending  = 1'b0;
            res.event_value   = VAL_SAFE_FALSE;
            res.monitor_event = mon_on;
        end

        res.display_value = nxt.shown_value;
        res.output_state  = nxt.out_state;
    end

endmodule

`default_nettype wire
